[sv/json_data_string_unwrapper_core_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef JSON_DATA_STRING_UNWRAPPER_CORE_MACROS_SVH
`define JSON_DATA_STRING_UNWRAPPER_CORE_MACROS_SVH

// General form: explicit clock and active-low reset.
`define JDSU_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Common form: the block's own clock and reset.
`define JDSU_ASSERT(lbl, prop, msg) \
  `JDSU_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

[sv/jdsu_pkg.sv]
package jdsu_pkg;

  // Byte codes the matcher looks for.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] WsMax    = 8'h20;

  // The quoted key "data", quotes included.
  localparam int unsigned KeyLen = 6;
  localparam int unsigned KeyCntW = $clog2(KeyLen);

  typedef logic [KeyCntW-1:0] key_cnt_t;

  // Character of the key at a given position; positions past the end never match.
  function automatic logic [7:0] key_char(input key_cnt_t idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = ChQuote;
      3'd1:    c = 8'h64;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h61;
      3'd5:    c = ChQuote;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[sv/json_data_string_unwrapper_core.sv]
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | in_valid_i/in_ready_o  | in_byte_i, in_last_i
// out      | output    | out_valid_o/out_ready_i| out_byte_o, out_keep_o, out_last_o,
//          |           |                        | out_unterminated_o
//
// One byte per cycle; each request's result appears in the cycle after acceptance.
// Latency is set by the single output register behind the state update logic.
// The block takes a new byte whenever the output register is empty or is drained
// in the same cycle, so a stalled output holds the input back.
// Reset returns the matcher to the key search with no partial match; no clearing pass.
module json_data_string_unwrapper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_keep_o,
  output logic       out_last_o,
  output logic       out_unterminated_o
);
  import jdsu_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_QUOTE,
    PH_STRING,
    PH_ESCAPE
  } phase_e;

  phase_e     phase_q, phase_d;
  key_cnt_t   key_cnt_q, key_cnt_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_keep_q, out_last_q, out_unterm_q;
  logic       keep_d, unterm_d;
  logic       accept;

  // The output register is free when empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Key matcher and string scanner for one byte.
  always_comb begin
    key_cnt_t k;
    logic     hit;
    phase_d   = phase_q;
    key_cnt_d = key_cnt_q;
    keep_d    = 1'b1;
    unterm_d  = 1'b0;
    k         = key_cnt_q;

    // A broken colon or quote stage restarts the key match from scratch.
    if (phase_q == PH_COLON || phase_q == PH_QUOTE) begin
      k = '0;
    end
    hit = (k < key_cnt_t'(KeyLen)) && (in_byte_i == key_char(k));

    unique case (phase_q)
      PH_STRING: begin
        if (in_byte_i == ChBslash) begin
          keep_d  = 1'b0;
          phase_d = PH_ESCAPE;
        end else if (in_byte_i == ChQuote) begin
          keep_d    = 1'b0;
          phase_d   = PH_SEARCH;
          key_cnt_d = '0;
        end
      end
      PH_ESCAPE: begin
        phase_d = PH_STRING;
      end
      default: begin
        if ((phase_q == PH_COLON || phase_q == PH_QUOTE) && in_byte_i <= WsMax) begin
          // Blank bytes between key, colon and value are skipped.
          phase_d = phase_q;
        end else if (phase_q == PH_COLON && in_byte_i == ChColon) begin
          phase_d = PH_QUOTE;
        end else if (phase_q == PH_QUOTE && in_byte_i == ChQuote) begin
          keep_d  = 1'b0;
          phase_d = PH_STRING;
        end else if (hit && k == key_cnt_t'(KeyLen - 1)) begin
          phase_d   = PH_COLON;
          key_cnt_d = '0;
        end else if (hit) begin
          phase_d   = PH_SEARCH;
          key_cnt_d = k + key_cnt_t'(1);
        end else begin
          // The breaking byte may itself open a new key.
          phase_d   = PH_SEARCH;
          key_cnt_d = (in_byte_i == ChQuote) ? key_cnt_t'(1) : '0;
        end
      end
    endcase

    // Frame end: flag an open string and clear all match state.
    if (in_last_i) begin
      unterm_d  = (phase_d == PH_STRING) || (phase_d == PH_ESCAPE);
      phase_d   = PH_SEARCH;
      key_cnt_d = '0;
    end
  end

  // Matcher state advances only on accepted requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEARCH;
      key_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        key_cnt_q <= key_cnt_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q   <= keep_d ? in_byte_i : 8'h00;
      out_keep_q   <= keep_d;
      out_last_q   <= in_last_i;
      out_unterm_q <= unterm_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_byte_q;
  assign out_keep_o         = out_keep_q;
  assign out_last_o         = out_last_q;
  assign out_unterminated_o = out_unterm_q;

endmodule

[sv/jdsu_checker.sv]
`include "json_data_string_unwrapper_core_macros.svh"

module jdsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_keep_o,
  input logic       out_last_o,
  input logic       out_unterminated_o
);

  // A dropped byte always shows as zero.
  `JDSU_ASSERT(a_drop_zero, out_valid_o && !out_keep_o |-> out_byte_o == 8'h00, "dropped byte not zero")

  // An open string can only be flagged on the frame's final byte.
  `JDSU_ASSERT(a_unterm_last, out_valid_o && out_unterminated_o |-> out_last_o, "unterminated flag off frame end")

  // Every accepted request yields its result in the next cycle, with its frame mark.
  `JDSU_ASSERT(a_one_cycle, in_valid_i && in_ready_o |=> out_valid_o && out_last_o == $past(in_last_i), "result missing after request")

  // A stalled result stays in place.
  `JDSU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_keep_o), "stalled result changed")

endmodule

bind json_data_string_unwrapper_core jdsu_checker u_jdsu_checker (.*);

[tb/sv/json_data_string_unwrapper_core_test.sv]
`timescale 1ns / 1ps

module json_data_string_unwrapper_core_test;
  import jdsu_pkg::*;

  localparam int ClkPeriod  = 8;
  localparam int ResetCycles = 6;
  localparam int TotalReqs  = 1650;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 8;

  // Scan phases of the unwrapper.
  typedef enum logic [2:0] {
    PhSearch = 3'd0,
    PhColon  = 3'd1,
    PhQuote  = 3'd2,
    PhString = 3'd3,
    PhEscape = 3'd4
  } scan_phase_e;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic       keep;
    logic       last;
    logic       unterm;
  } unwrap_res_t;

  // One request; typed rows carry their expected result written out by hand.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    unwrap_res_t res;
  } byte_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_keep_o;
  logic       out_last_o;
  logic       out_unterminated_o;

  json_data_string_unwrapper_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_byte_i          (in_byte_i),
    .in_last_i          (in_last_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .out_keep_o         (out_keep_o),
    .out_last_o         (out_last_o),
    .out_unterminated_o (out_unterminated_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // The quoted key, quotes included.
  logic [7:0] key_bytes [KeyLen] = '{ChQuote, 8'h64, 8'h61, 8'h74, 8'h61, ChQuote};

  // Directed requests: extremes, a full key with blanks and escapes that ends
  // inside the value, and a broken key match whose quote starts a new key.
  byte_req_t directed_reqs [25] = '{
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{ChQuote, 1'b0, 1'b0, '0},
    '{8'h64, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h74, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{ChQuote, 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b0, '0},
    '{ChColon, 1'b0, 1'b0, '0},
    '{WsMax, 1'b0, 1'b0, '0},
    '{ChQuote, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ChBslash, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{ChQuote, 1'b0, 1'b1, '{ChQuote, 1'b1, 1'b0, 1'b0}},
    '{ChBslash, 1'b0, 1'b0, '0},
    '{ChQuote, 1'b1, 1'b1, '{ChQuote, 1'b1, 1'b1, 1'b1}},
    '{ChQuote, 1'b0, 1'b0, '0},
    '{ChQuote, 1'b0, 1'b0, '0},
    '{8'h64, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h74, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{ChQuote, 1'b0, 1'b0, '0},
    '{ChColon, 1'b0, 1'b0, '0},
    '{ChQuote, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
  };

  byte_req_t   req_q [$];
  byte_req_t   cur_req = '0;
  unwrap_res_t result_q [$];
  scan_phase_e scan_phase = PhSearch;
  key_cnt_t    match_cnt = '0;
  int          err_count = 0;
  int          cycle_cnt = 0;

  // Feed one byte to the key matcher while searching.
  function automatic void advance_key_match(input logic [7:0] b);
    scan_phase = PhSearch;
    if (match_cnt < KeyLen && b == key_bytes[match_cnt]) begin
      if (match_cnt == KeyLen - 1) begin
        scan_phase = PhColon;
        match_cnt = '0;
      end else begin
        match_cnt = match_cnt + 1'b1;
      end
    end else begin
      // A quote that breaks a match may open a new key.
      match_cnt = (b == ChQuote) ? key_cnt_t'(1) : key_cnt_t'(0);
    end
  endfunction

  // Predict the result for one byte and advance the scan state.
  function automatic unwrap_res_t unwrap_byte(input logic [7:0] b, input logic last);
    unwrap_res_t r;
    r.keep = 1'b1;
    r.unterm = 1'b0;
    case (scan_phase)
      PhColon: begin
        if (b == ChColon) begin
          scan_phase = PhQuote;
        end else if (b > WsMax) begin
          match_cnt = '0;
          advance_key_match(b);
        end
      end
      PhQuote: begin
        if (b == ChQuote) begin
          r.keep = 1'b0;
          scan_phase = PhString;
        end else if (b > WsMax) begin
          match_cnt = '0;
          advance_key_match(b);
        end
      end
      PhString: begin
        if (b == ChBslash) begin
          r.keep = 1'b0;
          scan_phase = PhEscape;
        end else if (b == ChQuote) begin
          r.keep = 1'b0;
          scan_phase = PhSearch;
          match_cnt = '0;
        end
      end
      PhEscape: begin
        scan_phase = PhString;
      end
      default: begin
        advance_key_match(b);
      end
    endcase
    // Every message ends with the matcher back at its reset state.
    if (last) begin
      r.unterm = (scan_phase == PhString || scan_phase == PhEscape);
      scan_phase = PhSearch;
      match_cnt = '0;
    end
    r.data = r.keep ? b : 8'h00;
    r.last = last;
    return r;
  endfunction

  // Bytes that matter to the matcher half of the time, any byte otherwise.
  function automatic logic [7:0] pick_byte();
    logic [7:0] picks [11] = '{ChQuote, ChColon, ChBslash, WsMax, 8'h00, 8'h09,
                               8'h64, 8'h61, 8'h74, 8'h7B, 8'h7D};
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return picks[$urandom_range(0, 10)];
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      err_count++;
    end
  endfunction

  // Predict each accepted request, then check each accepted result.
  always @(posedge clk_i) begin : score
    unwrap_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = unwrap_byte(cur_req.data, cur_req.last);
        if (cur_req.typed) begin
          want = cur_req.res;
        end
        result_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result with no request pending: byte 0x%0h", out_byte_o);
          err_count++;
        end else begin
          want = result_q.pop_front();
          check_field("out_byte", want.data, out_byte_o);
          check_field("out_keep", 8'(want.keep), 8'(out_keep_o));
          check_field("out_last", 8'(want.last), 8'(out_last_o));
          check_field("out_unterminated", 8'(want.unterm), 8'(out_unterminated_o));
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: a random stall before each result, with quiet stretches.
  initial begin : drain
    int  stall;
    bit  quiet;
    quiet = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        quiet = !quiet;
      end
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Stimulus build, reset, request driving and end of run.
  initial begin : stimulus
    logic [7:0] seg [$];
    logic [7:0] msg [$];
    logic [7:0] c;
    int         gap;
    bit         quiet;
    byte_req_t  req;

    quiet = 1'b0;
    foreach (directed_reqs[i]) req_q.push_back(directed_reqs[i]);

    // Random messages: mostly well-formed key/value pairs with random content,
    // some broken or cut short, mixed with noise.
    while (req_q.size() < TotalReqs) begin
      msg.delete();
      repeat ($urandom_range(1, 4)) begin
        seg.delete();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) seg.push_back(pick_byte());
        end else begin
          foreach (key_bytes[i]) seg.push_back(key_bytes[i]);
          repeat ($urandom_range(0, 2)) seg.push_back(8'($urandom_range(0, WsMax)));
          seg.push_back(ChColon);
          repeat ($urandom_range(0, 2)) seg.push_back(8'($urandom_range(0, WsMax)));
          seg.push_back(ChQuote);
          repeat ($urandom_range(0, 8)) begin
            c = pick_byte();
            if (c == ChQuote || c == ChBslash || $urandom_range(0, 7) == 0) begin
              seg.push_back(ChBslash);
            end
            seg.push_back(c);
          end
          seg.push_back(ChQuote);
          case ($urandom_range(0, 9))
            0: seg = seg[0:$urandom_range(0, seg.size() - 1)];
            1: seg[$urandom_range(0, seg.size() - 1)] = pick_byte();
            default: ;
          endcase
        end
        msg = {msg, seg};
      end
      foreach (msg[i]) begin
        req = '0;
        req.data = msg[i];
        req.last = (i == msg.size() - 1);
        req_q.push_back(req);
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (req_q[i]) begin
      if ($urandom_range(0, 39) == 0) begin
        quiet = !quiet;
      end
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i <= req_q[i].data;
      in_last_i <= req_q[i].last;
      cur_req <= req_q[i];
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
